/* hw/rtl/rbps_pkg.sv */
// Shared types, codes and the color packing function of the rectangle blitter.
`timescale 1ns / 1ps

package rbps_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_FILL    = 2'd0;
    localparam mode_t MODE_OUTLINE = 2'd1;
    localparam mode_t MODE_READ    = 2'd2;

    typedef logic cfg_index_t;

    localparam cfg_index_t CFG_ACTIVE_WIDTH  = 1'b0;
    localparam cfg_index_t CFG_ACTIVE_HEIGHT = 1'b1;

    // Width of a row base address: row (at most 189) times active width (at most 255).
    localparam int BASE_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DRAW,
        ST_READ,
        ST_RDATA
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    // Byte-swapped BGR565 word.
    function automatic logic [15:0] pack_rgb565(
        input logic [7:0] red,
        input logic [7:0] green,
        input logic [7:0] blue
    );
        return {green[4:2], red[7:3], blue[7:3], green[7:5]};
    endfunction

endpackage

/* hw/rtl/rectangle_blitter_pixel_store.sv */
// Top level of the rectangle blitter: size registers, pixel store and command sequencer.
// A fill or outline command sets up, then draws one pixel per cycle through the single
// write port of the pixel store. A read inside the active area waits for the registered
// store data; a read outside it, an empty rectangle or an unused mode skips the store.
// busy stays high for the whole command; the done word is shown for one cycle and cannot stall.
// Reset restores the active size to 128 by 64; the pixel store is not cleared.
`timescale 1ns / 1ps

module rectangle_blitter_pixel_store
    import rbps_pkg::*;
#(
    parameter int BUF_WIDTH  = 128,
    parameter int BUF_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_addr,
    input  logic [7:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [6:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [7:0]  rect_width,
    input  logic [6:0]  rect_height,
    input  logic [6:0]  border_width,
    output logic        done,
    output logic [15:0] pixel_color,
    output logic        any_clipped
);

    localparam int DEPTH  = BUF_WIDTH * BUF_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]        active_width_reg;
    logic [6:0]        active_height_reg;
    logic [7:0]        active_w;
    logic [6:0]        active_h;
    mem_ctl_t          mem_ctl;
    logic [ADDR_W-1:0] mem_addr;
    logic [15:0]       mem_wdata;
    logic [15:0]       mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_width_reg  <= 8'd128;
            active_height_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ACTIVE_WIDTH:  active_width_reg  <= cfg_data;
                CFG_ACTIVE_HEIGHT: active_height_reg <= cfg_data[6:0];
                default:           active_width_reg  <= active_width_reg;
            endcase
        end
    end

    // Sizes beyond the store act as the store's own size.
    assign active_w = (int'(active_width_reg) > BUF_WIDTH) ? 8'(BUF_WIDTH) : active_width_reg;
    assign active_h = (int'(active_height_reg) > BUF_HEIGHT) ? 7'(BUF_HEIGHT)
                                                             : active_height_reg;

    rbps_seq #(
        .ADDR_W (ADDR_W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .border_width (border_width),
        .active_w     (active_w),
        .active_h     (active_h),
        .mem_ctl      (mem_ctl),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata),
        .done         (done),
        .pixel_color  (pixel_color),
        .any_clipped  (any_clipped)
    );

    rbps_ram #(
        .WIDTH  (16),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_ctl.we),
        .re    (mem_ctl.re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    // The done word is only raised on the way back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done raised while a command is still running");

    // An accepted command always occupies the sequencer in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not make the block busy");

    // The store is only touched while a command runs.
    assert property (@(posedge clk) disable iff (!rst_n) (mem_ctl.we || mem_ctl.re) |-> busy)
        else $error("pixel store accessed while idle");

    // Store reads and writes never happen in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(mem_ctl.we && mem_ctl.re))
        else $error("pixel store read and written in one cycle");
`endif

endmodule

/* hw/rtl/rbps_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module rbps_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/rbps_seq.sv */
// Command sequencer: walks the rectangle one pixel a cycle through a shared address adder.
`timescale 1ns / 1ps

module rbps_seq
    import rbps_pkg::*;
#(
    parameter int ADDR_W = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mode_t             mode,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    input  logic [6:0]        pos_x,
    input  logic [5:0]        pos_y,
    input  logic [7:0]        rect_width,
    input  logic [6:0]        rect_height,
    input  logic [6:0]        border_width,
    input  logic [7:0]        active_w,
    input  logic [6:0]        active_h,
    output mem_ctl_t          mem_ctl,
    output logic [ADDR_W-1:0] mem_addr,
    output logic [15:0]       mem_wdata,
    input  logic [15:0]       mem_rdata,
    output logic              done,
    output logic [15:0]       pixel_color,
    output logic              any_clipped
);

    localparam int CALC_W = (ADDR_W > BASE_W + 1) ? ADDR_W : BASE_W + 1;

    state_t              state_reg,  state_next;
    mode_t               mode_reg,   mode_next;
    logic [15:0]         colour_reg, colour_next;
    logic [6:0]          px_reg,     px_next;
    logic [5:0]          py_reg,     py_next;
    logic [7:0]          rw_reg,     rw_next;
    logic [6:0]          rh_reg,     rh_next;
    logic [6:0]          bw_reg,     bw_next;
    logic [6:0]          r_reg,      r_next;
    logic [7:0]          c_reg,      c_next;
    logic [BASE_W-1:0]   base_reg,   base_next;
    logic                clip_reg,   clip_next;
    logic                done_reg,   done_next;
    logic [15:0]         pixel_color_reg, pixel_color_next;
    logic                any_clipped_reg, any_clipped_next;

    logic [7:0]          row;
    logic [8:0]          col;
    logic [13:0]         prod;
    logic [CALC_W-1:0]   addr_sum;
    logic                in_area;
    logic                on_border;
    logic                last_col;
    logic                last_row;

    // Shared datapath: pixel position, bounds test and store address.
    assign row      = {2'b0, py_reg} + {1'b0, r_reg};
    assign col      = {2'b0, px_reg} + {1'b0, c_reg};
    assign in_area  = (col < {1'b0, active_w}) && (row < {1'b0, active_h});
    assign prod     = 14'(py_reg) * 14'(active_w);
    assign addr_sum = CALC_W'(base_reg) + CALC_W'(col);
    assign mem_addr = addr_sum[ADDR_W-1:0];
    assign mem_wdata = colour_reg;

    assign on_border = (mode_reg == MODE_FILL)
                    || ({1'b0, r_reg} < {1'b0, bw_reg})
                    || (({1'b0, r_reg} + {1'b0, bw_reg}) >= {1'b0, rh_reg})
                    || (c_reg < {1'b0, bw_reg})
                    || (({1'b0, c_reg} + {2'b0, bw_reg}) >= {1'b0, rw_reg});

    assign last_col = (c_reg + 8'd1) == rw_reg;
    assign last_row = (r_reg + 7'd1) == rh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        colour_reg      <= colour_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        rw_reg          <= rw_next;
        rh_reg          <= rh_next;
        bw_reg          <= bw_next;
        r_reg           <= r_next;
        c_reg           <= c_next;
        base_reg        <= base_next;
        clip_reg        <= clip_next;
        pixel_color_reg <= pixel_color_next;
        any_clipped_reg <= any_clipped_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        colour_next      = colour_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        rw_next          = rw_reg;
        rh_next          = rh_reg;
        bw_next          = bw_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        base_next        = base_reg;
        clip_next        = clip_reg;
        done_next        = 1'b0;
        pixel_color_next = pixel_color_reg;
        any_clipped_next = any_clipped_reg;
        mem_ctl.we       = 1'b0;
        mem_ctl.re       = 1'b0;
        busy             = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    mode_next   = mode;
                    colour_next = pack_rgb565(red, green, blue);
                    px_next     = pos_x;
                    py_next     = pos_y;
                    rw_next     = rect_width;
                    rh_next     = rect_height;
                    bw_next     = border_width;
                    r_next      = 7'd0;
                    c_next      = 8'd0;
                    clip_next   = 1'b0;
                    state_next  = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                base_next = BASE_W'(prod);
                case (mode_reg)
                    MODE_FILL, MODE_OUTLINE:
                    begin
                        if (rw_reg == 8'd0 || rh_reg == 7'd0)
                        begin
                            done_next        = 1'b1;
                            pixel_color_next = 16'd0;
                            any_clipped_next = 1'b0;
                            state_next       = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_DRAW;
                        end
                    end
                    MODE_READ:
                    begin
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        done_next        = 1'b1;
                        pixel_color_next = 16'd0;
                        any_clipped_next = 1'b0;
                        state_next       = ST_IDLE;
                    end
                endcase
            end

            ST_DRAW:
            begin
                mem_ctl.we = on_border && in_area;
                clip_next  = clip_reg || (on_border && !in_area);
                if (last_col)
                begin
                    c_next = 8'd0;
                    if (last_row)
                    begin
                        done_next        = 1'b1;
                        pixel_color_next = 16'd0;
                        any_clipped_next = clip_reg || (on_border && !in_area);
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        r_next    = r_reg + 7'd1;
                        base_next = base_reg + BASE_W'(active_w);
                    end
                end
                else
                begin
                    c_next = c_reg + 8'd1;
                end
            end

            ST_READ:
            begin
                if (in_area)
                begin
                    mem_ctl.re = 1'b1;
                    state_next = ST_RDATA;
                end
                else
                begin
                    done_next        = 1'b1;
                    pixel_color_next = 16'd0;
                    any_clipped_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_RDATA:
            begin
                done_next        = 1'b1;
                pixel_color_next = mem_rdata;
                any_clipped_next = 1'b0;
                state_next       = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done        = done_reg;
    assign pixel_color = pixel_color_reg;
    assign any_clipped = any_clipped_reg;

endmodule
